>>> rtl/core/tcp_pkg.sv
// tcp_pkg: shared types, constants and helpers of the timecode text parser
`timescale 1ns / 1ps

package tcp_pkg;

  // field and datapath widths
  localparam int CHAR_W  = 16;
  localparam int NUM_W   = 22;
  localparam int DEN_W   = 16;
  localparam int TICK_W  = 63;
  localparam int MA_W    = 64;
  localparam int MB_W    = 42;
  localparam int PROD_W  = 80;
  localparam int VAL_W   = 40;
  localparam int DIG_W   = 4;
  localparam int FRAC_W  = 24;
  localparam int SEC_W   = 40;
  localparam int UNIT_W  = 40;
  localparam int NOM_W   = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 22;

  // character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
  localparam logic [CHAR_W-1:0] CH_F_LO  = 16'h0066;
  localparam logic [CHAR_W-1:0] CH_F_UP  = 16'h0046;
  localparam logic [CHAR_W-1:0] CH_COLON = 16'h003A;
  localparam logic [CHAR_W-1:0] CH_POINT = 16'h002E;

  // arithmetic constants
  localparam logic [23:0]      TICKS_PER_SEC = 24'd10000000;
  localparam logic [19:0]      MICRO_SCALE   = 20'd1000000;
  localparam logic [NOM_W-1:0] NOM_CAP       = 17'd100000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEN = 1'b1;

  typedef enum logic [1:0] {
    FORM_FRAME,
    FORM_FOUR,
    FORM_TIME
  } form_e;

  typedef enum logic [3:0] {
    STEP_UNIT,
    STEP_SCALE,
    STEP_TOPM,
    STEP_NOM,
    STEP_HMS,
    STEP_SEC,
    STEP_NPROD,
    STEP_IDX,
    STEP_PROD,
    STEP_QUOT
  } step_e;

  typedef struct packed {
    logic  char_we;
    logic  prep;
    logic  start;
    step_e step;
    logic  load_out;
    logic  res_ok;
  } cmd_t;

  typedef struct packed {
    logic  pre_ok;
    form_e form;
    logic  nom_ok;
    logic  op_done;
  } stat_t;

  // scale of a fraction with k digits up to seven digits
  function automatic logic [FRAC_W-1:0] frac_scale(input logic [DIG_W-1:0] k);
    logic [FRAC_W-1:0] r;
    case (k)
      4'd1:    r = 24'd1000000;
      4'd2:    r = 24'd100000;
      4'd3:    r = 24'd10000;
      4'd4:    r = 24'd1000;
      4'd5:    r = 24'd100;
      4'd6:    r = 24'd10;
      default: r = 24'd1;
    endcase
    return r;
  endfunction

  // steps that run on the divider
  function automatic logic is_div_step(input step_e s);
    return (s == STEP_NOM) || (s == STEP_IDX) || (s == STEP_QUOT);
  endfunction

endpackage

>>> rtl/core/tcp_mul.sv
// tcp_mul: shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module tcp_mul
  import tcp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MA_W-1:0]   a_i,
  input  logic [MB_W-1:0]   b_i,
  output logic              done_o,
  output logic [PROD_W-1:0] prod_o
);

  localparam int CNT_W = $clog2(MB_W + 1);

  logic [PROD_W-1:0] acc_q, acc_d, a_q, a_d;
  logic [MB_W-1:0]   b_q, b_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  // next state of the shift-add loop
  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      a_d    = {{(PROD_W-MA_W){1'b0}}, a_i};
      b_d    = b_i;
      cnt_d  = CNT_W'(MB_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d   = {a_q[PROD_W-2:0], 1'b0};
      b_d   = {1'b0, b_q[MB_W-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> rtl/core/tcp_div.sv
// tcp_div: restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tcp_div
  import tcp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] n_i,
  input  logic [MB_W-1:0]   d_i,
  output logic              done_o,
  output logic [PROD_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] nq_q, nq_d;
  logic [MB_W-1:0]   r_q, r_d, d_q, d_d;
  logic [MB_W:0]     rs;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  // shift in the next dividend bit, subtract where it fits
  always_comb begin
    nq_d   = nq_q;
    r_d    = r_q;
    d_d    = d_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rs     = {r_q, nq_q[PROD_W-1]};
    if (start_i) begin
      nq_d   = n_i;
      r_d    = '0;
      d_d    = d_i;
      cnt_d  = CNT_W'(PROD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rs >= {1'b0, d_q}) begin
        r_d  = MB_W'(rs - {1'b0, d_q});
        nq_d = {nq_q[PROD_W-2:0], 1'b1};
      end else begin
        r_d  = rs[MB_W-1:0];
        nq_d = {nq_q[PROD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q <= nq_d;
    r_q  <= r_d;
    d_q  <= d_d;
  end

  assign done_o = done_q;
  assign quot_o = nq_q;

endmodule

>>> rtl/core/tcp_datapath.sv
// tcp_datapath: parse state, frame rate registers, arithmetic steps and output item
`timescale 1ns / 1ps

module tcp_datapath
  import tcp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  logic [CHAR_W-1:0]     char_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [TICK_W-1:0]     ticks_o,
  output logic                  valid_res_o
);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_BODY,
    PH_TRAIL
  } phase_e;

  phase_e            phase_q, phase_d;
  logic              fpm_q, fpm_d, point_q, point_d, err_q, err_d;
  logic [1:0]        idx_q, idx_d;
  logic [VAL_W-1:0]  fval_q [4];
  logic [VAL_W-1:0]  fval_d [4];
  logic [DIG_W-1:0]  fdig_q [4];
  logic [DIG_W-1:0]  fdig_d [4];
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [DIG_W-1:0]  fracdig_q, fracdig_d;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;

  // frame rate registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= NUM_W'(30);
      den_q <= DEN_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_NUM) num_q <= cfg_data_i[NUM_W-1:0];
      if (cfg_index_i == CFG_DEN) den_q <= cfg_data_i[DEN_W-1:0];
    end
  end

  // one character into the parse state
  logic              ws, dig, go;
  logic [3:0]        dval;
  logic [DIG_W-1:0]  ndig;
  phase_e            ph;
  always_comb begin
    phase_d   = phase_q;
    fpm_d     = fpm_q;
    point_d   = point_q;
    err_d     = err_q;
    idx_d     = idx_q;
    fval_d    = fval_q;
    fdig_d    = fdig_q;
    frac_d    = frac_q;
    fracdig_d = fracdig_q;
    ws   = (char_i == CH_SPACE) || (char_i == CH_TAB);
    dig  = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
    dval = char_i[3:0];
    go   = 1'b1;
    ph   = phase_q;
    ndig = '0;
    if (cmd_i.load_out) begin
      phase_d   = PH_LEAD;
      fpm_d     = 1'b0;
      point_d   = 1'b0;
      err_d     = 1'b0;
      idx_d     = '0;
      frac_d    = '0;
      fracdig_d = '0;
      for (int i = 0; i < 4; i++) begin
        fval_d[i] = '0;
        fdig_d[i] = '0;
      end
    end else if (cmd_i.char_we) begin
      if (ph == PH_LEAD) begin
        if (ws) begin
          go = 1'b0;
        end else begin
          ph = PH_BODY;
          if ((char_i == CH_F_LO) || (char_i == CH_F_UP)) begin
            fpm_d = 1'b1;
            go    = 1'b0;
          end
        end
      end
      if (go) begin
        if (ph == PH_TRAIL) begin
          if (!ws) err_d = 1'b1;
        end else if (ws) begin
          ph = PH_TRAIL;
        end else if (dig) begin
          if (point_q && !fpm_q) begin
            ndig = (fracdig_q == 4'd15) ? fracdig_q : fracdig_q + 1'b1;
            fracdig_d = ndig;
            if (ndig <= 4'd7) frac_d = FRAC_W'(frac_q * 4'd10) + FRAC_W'(dval);
          end else begin
            ndig = (fdig_q[idx_q] == 4'd15) ? fdig_q[idx_q] : fdig_q[idx_q] + 1'b1;
            fdig_d[idx_q] = ndig;
            if (ndig <= 4'd12)
              fval_d[idx_q] = VAL_W'(fval_q[idx_q] * 4'd10) + VAL_W'(dval);
          end
        end else if (fpm_q) begin
          err_d = 1'b1;
        end else if (char_i == CH_COLON) begin
          if (point_q || (idx_q == 2'd3)) err_d = 1'b1;
          else idx_d = idx_q + 1'b1;
        end else if (char_i == CH_POINT) begin
          if (point_q) err_d = 1'b1;
          point_d = 1'b1;
        end else begin
          err_d = 1'b1;
        end
      end
      phase_d = ph;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEAD;
      fpm_q     <= 1'b0;
      point_q   <= 1'b0;
      err_q     <= 1'b0;
      idx_q     <= '0;
      frac_q    <= '0;
      fracdig_q <= '0;
      for (int i = 0; i < 4; i++) begin
        fval_q[i] <= '0;
        fdig_q[i] <= '0;
      end
    end else begin
      phase_q   <= phase_d;
      fpm_q     <= fpm_d;
      point_q   <= point_d;
      err_q     <= err_d;
      idx_q     <= idx_d;
      frac_q    <= frac_d;
      fracdig_q <= fracdig_d;
      fval_q    <= fval_d;
      fdig_q    <= fdig_d;
    end
  end

  // digit count within limits
  function automatic logic hd(input logic [DIG_W-1:0] n, input logic [DIG_W-1:0] most);
    return (n >= 4'd1) && (n <= most);
  endfunction

  // form and range checks on the finished string
  form_e form;
  logic  pre_ok;
  always_comb begin
    pre_ok = 1'b1;
    if (fpm_q) form = FORM_FRAME;
    else if (idx_q == 2'd3) form = FORM_FOUR;
    else form = FORM_TIME;
    if (err_q || (phase_q == PH_LEAD) || (num_q == '0) || (den_q == '0)) begin
      pre_ok = 1'b0;
    end else begin
      case (form)
        FORM_FRAME: pre_ok = hd(fdig_q[0], 4'd12);
        FORM_FOUR: begin
          pre_ok = !point_q && hd(fdig_q[0], 4'd6) && hd(fdig_q[1], 4'd2) &&
                   hd(fdig_q[2], 4'd2) && hd(fdig_q[3], 4'd6) &&
                   (fval_q[1] < VAL_W'(60)) && (fval_q[2] < VAL_W'(60));
        end
        default: begin
          case (idx_q)
            2'd0: pre_ok = hd(fdig_q[0], 4'd9);
            2'd1: pre_ok = hd(fdig_q[0], 4'd7) && hd(fdig_q[1], 4'd2) &&
                           (fval_q[1] < VAL_W'(60));
            default: pre_ok = hd(fdig_q[0], 4'd6) && hd(fdig_q[1], 4'd2) &&
                              (fval_q[1] < VAL_W'(60)) && hd(fdig_q[2], 4'd2) &&
                              (fval_q[2] < VAL_W'(60));
          endcase
          if (point_q && !hd(fracdig_q, 4'd7)) pre_ok = 1'b0;
        end
      endcase
    end
  end

  // hours, minutes and seconds of the string, and the scaled fraction
  logic [19:0]       hh;
  logic [23:0]       mm;
  logic [29:0]       ss;
  logic [SEC_W-1:0]  secs_q;
  logic [FRAC_W-1:0] fracs_q;
  logic [47:0]       frac_prod;
  always_comb begin
    hh = '0;
    mm = '0;
    ss = fval_q[0][29:0];
    if (idx_q == 2'd1) begin
      mm = fval_q[0][23:0];
      ss = fval_q[1][29:0];
    end else if (idx_q != 2'd0) begin
      hh = fval_q[0][19:0];
      mm = fval_q[1][23:0];
      ss = fval_q[2][29:0];
    end
    frac_prod = frac_q * frac_scale(fracdig_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      secs_q  <= SEC_W'((SEC_W'(SEC_W'(hh) * 6'd60) + SEC_W'(mm)) * 6'd60) + SEC_W'(ss);
      fracs_q <= point_q ? frac_prod[FRAC_W-1:0] : '0;
    end
  end

  // shared multiplier and divider
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b, div_d;
  logic [PROD_W-1:0] div_n, prod, quot;
  logic              mul_done, div_done;
  logic [UNIT_W-1:0] unit_q;
  logic [35:0]       aux_q;
  logic [NOM_W-1:0]  nom_q;
  logic [MA_W-1:0]   total_q;
  logic [PROD_W-1:0] p_q;
  logic [TICK_W-1:0] ticks_q;

  // operands of the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = p_q;
    div_d = MB_W'(num_q);
    case (cmd_i.step)
      STEP_UNIT:  begin mul_a = MA_W'(den_q); mul_b = MB_W'(TICKS_PER_SEC); end
      STEP_SCALE: begin mul_a = MA_W'(den_q); mul_b = MB_W'(MICRO_SCALE); end
      STEP_TOPM:  begin mul_a = MA_W'(num_q); mul_b = MB_W'(MICRO_SCALE); end
      STEP_NOM: begin
        div_n = p_q + PROD_W'(aux_q) - PROD_W'(den_q) - PROD_W'(1);
        div_d = MB_W'(aux_q);
      end
      STEP_HMS:   begin mul_a = MA_W'(secs_q); mul_b = MB_W'(nom_q); end
      STEP_SEC:   begin mul_a = MA_W'(secs_q); mul_b = MB_W'(TICKS_PER_SEC); end
      STEP_NPROD: begin mul_a = total_q; mul_b = MB_W'({num_q, 1'b0}); end
      STEP_IDX:   div_d = MB_W'({unit_q, 1'b0});
      STEP_PROD: begin
        mul_a = (form == FORM_FRAME) ? MA_W'(fval_q[0]) : total_q;
        mul_b = MB_W'(unit_q);
      end
      default: ;
    endcase
  end

  tcp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && !is_div_step(cmd_i.step)),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  tcp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && is_div_step(cmd_i.step)),
    .n_i     (div_n),
    .d_i     (div_d),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // capture the result of a finished step
  always_ff @(posedge clk_i) begin
    if (mul_done || div_done) begin
      case (cmd_i.step)
        STEP_UNIT:  unit_q  <= prod[UNIT_W-1:0];
        STEP_SCALE: aux_q   <= prod[35:0];
        STEP_TOPM:  p_q     <= prod;
        STEP_NOM: begin
          if (quot == '0) nom_q <= NOM_W'(1);
          else if (quot > PROD_W'(NOM_CAP)) nom_q <= NOM_CAP;
          else nom_q <= quot[NOM_W-1:0];
        end
        STEP_HMS:   total_q <= prod[MA_W-1:0] + MA_W'(fval_q[3]);
        STEP_SEC:   total_q <= prod[MA_W-1:0] + MA_W'(fracs_q);
        STEP_NPROD: p_q     <= prod + PROD_W'(unit_q);
        STEP_IDX:   total_q <= quot[MA_W-1:0];
        STEP_PROD:  p_q     <= prod;
        STEP_QUOT: begin
          if (quot[PROD_W-1:TICK_W] != '0) ticks_q <= '1;
          else ticks_q <= quot[TICK_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // output item register
  logic [TICK_W-1:0] out_ticks_q;
  logic              out_ok_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_ok_q    <= cmd_i.res_ok;
      out_ticks_q <= cmd_i.res_ok ? ticks_q : '0;
    end
  end

  assign ticks_o        = out_ticks_q;
  assign valid_res_o    = out_ok_q;
  assign stat_o.pre_ok  = pre_ok;
  assign stat_o.form    = form;
  assign stat_o.nom_ok  = fval_q[3] < VAL_W'(nom_q);
  assign stat_o.op_done = mul_done || div_done;

endmodule

>>> rtl/core/tcp_ctrl.sv
// tcp_ctrl: sequencer for character intake, arithmetic steps and output handshake
`timescale 1ns / 1ps

module tcp_ctrl
  import tcp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_last_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_WAIT,
    ST_NEXT,
    ST_OUT
  } state_e;

  state_e state_q;
  step_e  step_q;
  logic   ok_q, out_valid_q;
  logic   accept, load;

  // step order for each form
  function automatic step_e next_step(input step_e s, input form_e f);
    step_e n;
    case (s)
      STEP_UNIT: begin
        case (f)
          FORM_FRAME: n = STEP_PROD;
          FORM_FOUR:  n = STEP_SCALE;
          default:    n = STEP_SEC;
        endcase
      end
      STEP_SCALE: n = STEP_TOPM;
      STEP_TOPM:  n = STEP_NOM;
      STEP_NOM:   n = STEP_HMS;
      STEP_HMS:   n = STEP_PROD;
      STEP_SEC:   n = STEP_NPROD;
      STEP_NPROD: n = STEP_IDX;
      STEP_IDX:   n = STEP_PROD;
      default:    n = STEP_QUOT;
    endcase
    return n;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load       = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_UNIT;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i && !load) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (accept && in_last_i) state_q <= ST_PREP;
        ST_PREP: begin
          step_q <= STEP_UNIT;
          ok_q   <= stat_i.pre_ok;
          state_q <= stat_i.pre_ok ? ST_RUN : ST_OUT;
        end
        ST_RUN:  state_q <= ST_WAIT;
        ST_WAIT: if (stat_i.op_done) state_q <= ST_NEXT;
        ST_NEXT: begin
          if (step_q == STEP_QUOT) begin
            state_q <= ST_OUT;
          end else if ((step_q == STEP_NOM) && !stat_i.nom_ok) begin
            ok_q    <= 1'b0;
            state_q <= ST_OUT;
          end else begin
            step_q  <= next_step(step_q, stat_i.form);
            state_q <= ST_RUN;
          end
        end
        ST_OUT: begin
          if (load) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cmd_o.char_we  = accept;
  assign cmd_o.prep     = (state_q == ST_PREP);
  assign cmd_o.start    = (state_q == ST_RUN);
  assign cmd_o.step     = step_q;
  assign cmd_o.load_out = load;
  assign cmd_o.res_ok   = ok_q;

  // a last character is followed by evaluation, not by another intake
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |=> (state_q == ST_PREP) && !in_ready_o)
    else $error("intake open after last character");

  // a result item appears only through a load
  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(load))
    else $error("result item without load");

  // a unit is never started while the parser takes characters
  a_no_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> !in_ready_o && !cmd_o.load_out)
    else $error("arithmetic start outside evaluation");

endmodule

>>> rtl/core/timecode_text_parser_top.sv
// timecode_text_parser_top: top level of the timecode text parser
`timescale 1ns / 1ps

// Takes a timecode string one character per item and answers with one result
// item on the character marked tlast: tuser is the valid flag, tdata the
// frame-aligned time in 100 ns ticks (zero when rejected). Plain characters
// are taken back to back. The last character starts an evaluation that runs
// on one shared 42-step shift-add multiplier and one 80-step restoring
// divider; input tready is low until the result is loaded into the output
// register, which then waits for m_axis_tready without blocking the next
// string. Frame rate registers: index 0 numerator (reset 30), index 1
// denominator (reset 1); write them only while no string is in progress.

module timecode_text_parser_top
  import tcp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [15:0] character
  input  logic                  s_axis_tlast,
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [63:0]           m_axis_tdata,   // [62:0] pts_ticks, [63] zero
  output logic                  m_axis_tuser,   // [0] valid_res
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t              cmd;
  stat_t             stat;
  logic [TICK_W-1:0] ticks;

  assign cfg_ready_o = 1'b1;

  tcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  tcp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .char_i      (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ticks_o     (ticks),
    .valid_res_o (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, ticks};

endmodule
